FILE: rtl/gauss_gauss_laplace_edge_cascade_assert.svh
// assertion macros for the edge cascade
`ifndef GAUSS_GAUSS_LAPLACE_EDGE_CASCADE_ASSERT_SVH
`define GAUSS_GAUSS_LAPLACE_EDGE_CASCADE_ASSERT_SVH

// same-cycle implication
`define GGLE_CHECK(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ggle check failed");

// next-cycle implication
`define GGLE_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ggle next-cycle check failed");

`endif

FILE: rtl/ggle_pkg.sv
// shared types and constants for the edge cascade
package ggle_pkg;
   localparam int MaxWidth = 4096;
   localparam int QDepth = 16;
   localparam logic [12:0] MinSize = 13'd5;
   localparam logic [12:0] MaxSize = 13'd4096;
   localparam logic [12:0] ResetWidth = 13'd640;
   localparam logic [12:0] ResetHeight = 13'd480;
   localparam logic [4:0] CreditMax = 5'd16;

   localparam logic [1:0] REG_WIDTH = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;

   typedef struct packed {
      logic       kind;
      logic [7:0] pixel;
   } req_type;

   typedef struct packed {
      logic [7:0] edge_pixel;
      logic       last;
   } rsp_type;

   // first[0] marks frame position 0 for the cell that sees this tag
   typedef struct packed {
      logic [2:0] first;
      logic       emit;
      logic       last;
   } tag_type;

   typedef struct packed {
      logic       valid;
      tag_type    tag;
      logic [7:0] val;
   } tok_type;
endpackage

FILE: rtl/gauss_gauss_laplace_edge_cascade.sv
// top level: two gaussian cells and a laplacian cell in a row
// Edge detector for 8-bit grey frames sent in raster order.
// req channel: one item per pixel (kind 0), then padding items (kind 1)
// that push out the tail; padding before the frame is complete is dropped.
// rsp channel: one edge pixel per frame position, last marks the final one.
// The result for position q follows the item numbered q + 6*width + 6;
// after that item is accepted the result passes through
// three 3-stage cells and a 16-entry result queue.
// Throughput is one item per cycle while req_stall is low; each cell
// reads and writes its line memory once per item, on separate ports.
// csr port sets width and height (clamped to 5..4096); a write to either restarts
// the frame. Line memories are not cleared; stale reads only reach zeroed border results.
// Reset sets 640x480 and empties the pipeline and the queue.
// When the receiver stalls, results collect in the queue; req_stall rises
// once 16 results are queued or in flight.
module gauss_gauss_laplace_edge_cascade (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ggle_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ggle_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [12:0]       csr_wdata
);
   import ggle_pkg::*;

   logic [12:0] img_w_ff, img_h_ff, cfg_val;
   logic [24:0] p_ff;
   logic [4:0]  credit_ff;
   logic [25:0] total, last_pos;
   logic [15:0] lag2, lag3;
   logic        req_acc, rsp_acc, drop, cfg_hit;
   tok_type     tok0, tok1, tok2, tok3;
   rsp_type     q_data;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;
   assign req_stall = (credit_ff >= CreditMax);
   assign cfg_hit = csr_wr_en && ((csr_index == REG_WIDTH) || (csr_index == REG_HEIGHT));

   always_comb begin
      cfg_val = csr_wdata;
      if (cfg_val < MinSize) cfg_val = MinSize;
      if (cfg_val > MaxSize) cfg_val = MaxSize;
      total = {13'd0, img_w_ff} * {13'd0, img_h_ff};
      lag2 = ({3'd0, img_w_ff} << 2) + 16'd4;
      lag3 = ({3'd0, img_w_ff} << 2) + ({3'd0, img_w_ff} << 1) + 16'd6;
      last_pos = total + {10'd0, lag3} - 26'd1;
      drop = req_data.kind && ({1'b0, p_ff} < total);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= ResetWidth;
         img_h_ff <= ResetHeight;
         p_ff <= '0;
         credit_ff <= '0;
      end else begin
         if (csr_wr_en && (csr_index == REG_WIDTH)) img_w_ff <= cfg_val;
         if (csr_wr_en && (csr_index == REG_HEIGHT)) img_h_ff <= cfg_val;
         if (cfg_hit) begin
            p_ff <= '0;
         end else if (req_acc && !drop) begin
            p_ff <= ({1'b0, p_ff} == last_pos) ? 25'd0 : p_ff + 25'd1;
         end
         credit_ff <= credit_ff + {4'd0, tok0.valid && tok0.tag.emit} - {4'd0, rsp_acc};
      end
   end

   always_comb begin
      tok0.valid = req_acc && !drop;
      tok0.tag.first[0] = (p_ff == 25'd0);
      tok0.tag.first[1] = (p_ff == {9'd0, lag2 >> 1});
      tok0.tag.first[2] = (p_ff == {9'd0, lag2});
      tok0.tag.emit = (p_ff >= {9'd0, lag3});
      tok0.tag.last = ({1'b0, p_ff} == last_pos);
      tok0.val = req_data.pixel;
   end

   ggle_cell u_blur1 (
      .clock(clock), .reset(reset), .lap_mode(1'b0),
      .img_width(img_w_ff), .img_height(img_h_ff), .tok_i(tok0), .tok_o(tok1)
   );

   ggle_cell u_blur2 (
      .clock(clock), .reset(reset), .lap_mode(1'b0),
      .img_width(img_w_ff), .img_height(img_h_ff), .tok_i(tok1), .tok_o(tok2)
   );

   ggle_cell u_laplace (
      .clock(clock), .reset(reset), .lap_mode(1'b1),
      .img_width(img_w_ff), .img_height(img_h_ff), .tok_i(tok2), .tok_o(tok3)
   );

   assign q_data = {tok3.val, tok3.tag.last};

   ggle_out_queue u_queue (
      .clock(clock), .reset(reset),
      .push(tok3.valid && tok3.tag.emit), .push_data(q_data),
      .pop(rsp_acc), .out_valid(rsp_valid), .out_data(rsp_data)
   );

`include "gauss_gauss_laplace_edge_cascade_assert.svh"

   `GGLE_CHECK(credit_bound, 1'b1, credit_ff <= CreditMax)
   `GGLE_CHECK(rsp_has_credit, rsp_valid, credit_ff != 5'd0)
   `GGLE_CHECK_NEXT(cfg_restart, cfg_hit, p_ff == 25'd0)
endmodule

FILE: rtl/ggle_cell.sv
// one 5x5 filter cell: line memory, column sums, weighted total
module ggle_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              lap_mode,
   input  logic [12:0]       img_width,
   input  logic [12:0]       img_height,
   input  ggle_pkg::tok_type tok_i,
   output ggle_pkg::tok_type tok_o
);
   import ggle_pkg::*;

   logic [11:0] col_ff, col_in, cur_col;
   logic [12:0] row_ff, row_in, cur_row;
   logic        interior;

   logic        s1_valid_ff;
   tag_type     s1_tag_ff;
   logic [7:0]  s1_val_ff;
   logic [11:0] s1_col_ff;
   logic        s1_int_ff;
   logic [31:0] rd_ff;
   logic [31:0] line_mem [MaxWidth];

   logic [11:0] csum_ff [5];
   logic [7:0]  mid_ff [3];
   logic        s2_valid_ff;
   tag_type     s2_tag_ff;
   logic        s2_int_ff;

   logic [7:0]  ca, cb, cc, cd, ce;
   logic [11:0] gcol, csum;
   logic [10:0] lcol;
   logic [15:0] gtot;
   logic [13:0] ltot;
   logic [14:0] lmid;
   logic signed [15:0] lres;
   logic [7:0]  result;

   always_comb begin
      cur_col = tok_i.tag.first[0] ? 12'd0 : col_ff;
      cur_row = tok_i.tag.first[0] ? 13'd0 : row_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (tok_i.valid) begin
         if ({1'b0, cur_col} + 13'd1 >= img_width) begin
            col_in = 12'd0;
            row_in = cur_row + 13'd1;
         end else begin
            col_in = cur_col + 12'd1;
            row_in = cur_row;
         end
      end
      // window center sits two rows up and two columns left
      interior = (cur_col >= 12'd4) && (cur_row >= 13'd4) && (cur_row < img_height);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         s1_valid_ff <= tok_i.valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // line memory holds the four rows above, one column word per address
   always_ff @(posedge clock) begin
      if (tok_i.valid) begin
         rd_ff <= line_mem[cur_col];
      end
      if (s1_valid_ff) begin
         line_mem[s1_col_ff] <= {rd_ff[23:0], s1_val_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (tok_i.valid) begin
         s1_tag_ff <= tok_i.tag;
         s1_val_ff <= tok_i.val;
         s1_col_ff <= cur_col;
         s1_int_ff <= interior;
      end
   end

   always_comb begin
      ca = rd_ff[31:24];
      cb = rd_ff[23:16];
      cc = rd_ff[15:8];
      cd = rd_ff[7:0];
      ce = s1_val_ff;
      gcol = {4'd0, ca} + {4'd0, ce} + ({4'd0, cb} << 2) + ({4'd0, cd} << 2)
           + ({4'd0, cc} << 2) + ({4'd0, cc} << 1);
      lcol = {3'd0, ca} + {3'd0, cb} + {3'd0, cc} + {3'd0, cd} + {3'd0, ce};
      csum = lap_mode ? {1'b0, lcol} : gcol;
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         for (int i = 0; i < 4; i++) begin
            csum_ff[i] <= csum_ff[i+1];
         end
         csum_ff[4] <= csum;
         mid_ff[0] <= mid_ff[1];
         mid_ff[1] <= mid_ff[2];
         mid_ff[2] <= cc;
         s2_tag_ff <= s1_tag_ff;
         s2_int_ff <= s1_int_ff;
      end
   end

   always_comb begin
      gtot = {4'd0, csum_ff[0]} + {4'd0, csum_ff[4]}
           + ({4'd0, csum_ff[1]} << 2) + ({4'd0, csum_ff[3]} << 2)
           + ({4'd0, csum_ff[2]} << 2) + ({4'd0, csum_ff[2]} << 1);
      ltot = {2'd0, csum_ff[0]} + {2'd0, csum_ff[1]} + {2'd0, csum_ff[2]}
           + {2'd0, csum_ff[3]} + {2'd0, csum_ff[4]};
      lmid = ({7'd0, mid_ff[0]} << 4) + ({7'd0, mid_ff[0]} << 3) + {7'd0, mid_ff[0]};
      lres = $signed({2'b00, ltot}) - $signed({1'b0, lmid});
      if (lap_mode) begin
         if (lres > 16'sd255) begin
            result = 8'd255;
         end else if (lres < 16'sd0) begin
            result = 8'd0;
         end else begin
            result = lres[7:0];
         end
      end else begin
         result = gtot[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_o.valid <= 1'b0;
      end else begin
         tok_o.valid <= s2_valid_ff;
      end
      if (s2_valid_ff) begin
         tok_o.tag.first <= {1'b0, s2_tag_ff.first[2:1]};
         tok_o.tag.emit <= s2_tag_ff.emit;
         tok_o.tag.last <= s2_tag_ff.last;
         tok_o.val <= s2_int_ff ? result : 8'd0;
      end
   end
endmodule

FILE: rtl/ggle_out_queue.sv
// result queue that decouples the filter pipeline from the receiver
module ggle_out_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ggle_pkg::rsp_type push_data,
   input  logic              pop,
   output logic              out_valid,
   output ggle_pkg::rsp_type out_data
);
   import ggle_pkg::*;

   rsp_type    slot_ff [QDepth];
   logic [3:0] wr_ff, rd_ff;
   logic [4:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 4'd1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 4'd1;
         end
         cnt_ff <= cnt_ff + {4'd0, push} - {4'd0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   assign out_valid = (cnt_ff != 5'd0);
   assign out_data = slot_ff[rd_ff];
endmodule

FILE: bench/gauss_gauss_laplace_edge_cascade_tb.sv
// testbench for the two-gaussian plus laplacian edge cascade
module gauss_gauss_laplace_edge_cascade_tb;
   import ggle_pkg::*;

   localparam logic [1:0] REG_SPARE_LOW = 2'd2;
   localparam logic [1:0] REG_SPARE = 2'd3;
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_PAD = 1'b1;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_WAIT = 30;
   localparam int BINOM [5] = '{1, 4, 6, 4, 1};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [12:0] csr_wdata = '0;

   gauss_gauss_laplace_edge_cascade dut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_wr_en, .csr_index, .csr_wdata
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: three line stores, frame size and stream position
   logic [7:0] line_mem [3][5][MaxWidth];
   int unsigned frame_w = 640, frame_h = 480;
   int unsigned items_in_frame, out_col, out_row;
   rsp_type edge_queue [$];
   int errors, pixels_checked, items_sent, frames_done, cycles;
   int send_idle_pct, recv_idle_pct;

   function automatic logic [7:0] cell_output(int s, int unsigned pos);
      int unsigned ro, co;
      int unsigned gsum;
      int lsum;
      logic [7:0] v;
      ro = pos / frame_w;
      co = pos % frame_w;
      gsum = 0;
      lsum = 0;
      if (ro < 2 || ro + 2 >= frame_h || co < 2 || co + 2 >= frame_w) return 8'd0;
      for (int dy = 0; dy < 5; dy++) begin
         for (int dx = 0; dx < 5; dx++) begin
            v = line_mem[s][(ro + dy - 2) % 5][co + dx - 2];
            if (s == 2) lsum += (dy == 2 && dx == 2) ? -24 * int'(v) : int'(v);
            else gsum += BINOM[dy] * BINOM[dx] * v;
         end
      end
      if (s != 2) return gsum[15:8];
      if (lsum > 255) return 8'd255;
      if (lsum < 0) return 8'd0;
      return lsum[7:0];
   endfunction

   function automatic void write_line(int s, int unsigned pos, logic [7:0] v);
      line_mem[s][(pos / frame_w) % 5][pos % frame_w] = v;
   endfunction

   function automatic void predict_item(req_type it);
      int unsigned total, lag, p, q1, q2, q3;
      rsp_type r;
      total = frame_w * frame_h;
      lag = 2 * frame_w + 2;
      p = items_in_frame;
      if (p < total) begin
         if (it.kind == KIND_PAD) return;
         write_line(0, p, it.pixel);
      end
      items_in_frame = p + 1;
      if (p < lag) return;
      q1 = p - lag;
      if (q1 < total) write_line(1, q1, cell_output(0, q1));
      if (q1 < lag) return;
      q2 = q1 - lag;
      if (q2 < total) write_line(2, q2, cell_output(1, q2));
      if (q2 < lag) return;
      q3 = q2 - lag;
      if (q3 >= total) return;
      r.edge_pixel = cell_output(2, q3);
      r.last = (out_row + 1 >= frame_h) && (out_col + 1 >= frame_w);
      edge_queue.push_back(r);
      if (r.last) begin
         items_in_frame = 0;
         out_col = 0;
         out_row = 0;
      end else if (out_col + 1 >= frame_w) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (edge_queue.size() == 0) begin
            $error("result with nothing expected: edge_pixel %0d last %0d",
                   rsp_data.edge_pixel, rsp_data.last);
            errors++;
         end else begin
            rsp_type e;
            e = edge_queue.pop_front();
            if (rsp_data.edge_pixel !== e.edge_pixel) begin
               $error("edge_pixel expected %0d got %0d", e.edge_pixel, rsp_data.edge_pixel);
               errors++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last expected %0d got %0d", e.last, rsp_data.last);
               errors++;
            end
            pixels_checked++;
            if (e.last) frames_done++;
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_item(logic kind, logic [7:0] pixel);
      req_type it;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      it.kind = kind;
      it.pixel = pixel;
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(it);
      items_sent++;
   endtask

   task automatic wait_results;
      req_valid <= 1'b0;
      while (edge_queue.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [12:0] value);
      logic [12:0] v;
      wait_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      v = (value < MinSize) ? MinSize : (value > MaxSize) ? MaxSize : value;
      if (idx == REG_WIDTH || idx == REG_HEIGHT) begin
         if (idx == REG_WIDTH) frame_w = {19'd0, v};
         else frame_h = {19'd0, v};
         items_in_frame = 0;
         out_col = 0;
         out_row = 0;
      end
   endtask

   function automatic logic [7:0] rand_pixel();
      // hard contrast drives the laplacian into its clamps
      if ($urandom_range(1)) return $urandom_range(1) ? 8'd255 : 8'd0;
      return 8'($urandom_range(255));
   endfunction

   // count items out from the current stream position; noise is dropped in-frame padding
   task automatic send_stream(int unsigned n, int noise_pct);
      for (int unsigned i = 0; i < n; i++) begin
         if (items_in_frame < frame_w * frame_h) begin
            if ($urandom_range(99) < noise_pct) send_item(KIND_PAD, 8'($urandom_range(255)));
            send_item(KIND_PIXEL, rand_pixel());
         end else begin
            send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
         end
      end
   endtask

   task automatic send_frame(int noise_pct);
      send_stream(frame_w * frame_h + 6 * frame_w + 6 - items_in_frame, noise_pct);
   endtask

   task automatic test_smallest_frame;
      write_reg(REG_WIDTH, 13'd0);
      write_reg(REG_HEIGHT, 13'd3);
      // checkerboard of full-scale pixels, padding slipped into the frame
      for (int i = 0; i < 25; i++) begin
         if (i % 7 == 3) send_item(KIND_PAD, 8'hff);
         send_item(KIND_PIXEL, ((i % 2) != 0) ? 8'd255 : 8'd0);
      end
      // pixel kind after the frame counts as padding
      for (int i = 0; i < 36; i++) send_item(i[0], 8'h5a);
   endtask

   task automatic test_register_writes;
      write_reg(REG_WIDTH, 13'd7);
      write_reg(REG_HEIGHT, 13'd6);
      send_stream(20, 0);
      // spare index leaves the frame alone
      write_reg(REG_SPARE, 13'h1fff);
      send_stream(15, 0);
      // a real write mid-frame restarts it
      write_reg(REG_HEIGHT, 13'd6);
      send_frame(0);
      write_reg(REG_SPARE_LOW, 13'd0);
      send_frame(5);
   endtask

   task automatic test_random_frames(int n);
      for (int f = 0; f < n; f++) begin
         write_reg(REG_WIDTH, 13'($urandom_range(5, 16)));
         write_reg(REG_HEIGHT, 13'($urandom_range(5, 10)));
         if (f == 1) begin
            // stop with results still in flight and let them all drain
            send_stream(frame_w * 8, 5);
            wait_results();
         end
         send_frame(5);
      end
   endtask

   task automatic test_largest_sizes;
      write_reg(REG_WIDTH, 13'h1fff);
      write_reg(REG_HEIGHT, 13'd5);
      send_stream(50, 1);
      write_reg(REG_WIDTH, 13'd5);
      write_reg(REG_HEIGHT, 13'd4096);
      send_stream(80, 1);
   endtask

   initial begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_smallest_frame();
      test_register_writes();
      send_idle_pct = 20;
      recv_idle_pct = 51;
      test_random_frames(2);
      send_idle_pct = 51;
      recv_idle_pct = 20;
      test_random_frames(2);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(1);
      test_largest_sizes();
      wait_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (edge_queue.size() != 0) begin
         $error("%0d edge pixels never arrived", edge_queue.size());
         errors++;
      end
      $display("sent %0d items: full frames from 5x5 to 16x10, partial ones at clamped sizes",
               items_sent);
      $display("checked %0d edge pixels in %0d complete frames", pixels_checked, frames_done);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

FILE: gauss_gauss_laplace_edge_cascade.f
+incdir+rtl
rtl/ggle_pkg.sv
rtl/ggle_cell.sv
rtl/ggle_out_queue.sv
rtl/gauss_gauss_laplace_edge_cascade.sv
bench/gauss_gauss_laplace_edge_cascade_tb.sv
